[rtl/bffa_pkg.sv]
// shared constants, codes and types of the bitmap first-fit allocator
package bffa_pkg;

  localparam int MAP_BITS  = 8192;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int FIELD_W   = 14;
  localparam int CODE_W    = 2;
  localparam logic [FIELD_W-1:0] COUNT_MAX = '1;
  localparam logic [FIELD_W-1:0] SIZE_MAX  = FIELD_W'(MAP_BITS);

  typedef enum logic [CODE_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_PRELOAD = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_t;

  typedef enum logic [CODE_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_RMW,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] data;
  } ram_wr_t;

endpackage

[rtl/bitmap_first_fit_allocator_top.sv]
// Bitmap first-fit allocator: 8192-entry allocation bitmap in 32-bit words plus a
// saturating free counter. One command is taken at a time. Allocate reads one bitmap
// word per cycle from the single-read-port word memory and tests it in the first-zero
// finder until it finds a free bit or reaches the last word. Free and preload read the
// word, then modify and write it back; load and out-of-range commands go straight to
// the result. A finished result sits in the output register while the next beat can be
// accepted. No clearing pass after reset: the bitmap reads as all free at once.
module bitmap_first_fit_allocator_top
  import bffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // number[13:0], count_value[27:14], zero pad
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // allocated[13:0], free_count[27:14], zero pad
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data
);

  fsm_t                 state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [FIELD_W-1:0]   num_r, num_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic [FIELD_W-1:0]   cnt_r, cnt_nxt;
  logic [FIELD_W-1:0]   map_size_r;
  logic [FIELD_W-1:0]   res_alloc_r, res_alloc_nxt;
  status_t              res_stat_r, res_stat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]   out_alloc_r, out_alloc_nxt;
  status_t              out_stat_r, out_stat_nxt;
  logic [FIELD_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic [FIELD_W-1:0]   in_number;
  logic [FIELD_W-1:0]   in_cval;
  cmd_t                 in_cmd;
  logic [FIELD_W-1:0]   in_num_m1;
  logic [FIELD_W-1:0]   num_m1;
  logic [FIELD_W-1:0]   size;
  logic [FIELD_W-1:0]   size_m1;
  logic [ADDR_W-1:0]    last_word;
  logic [FIELD_W-1:0]   lim;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]    rd_addr;
  ram_wr_t              wr;
  logic                 ffz_found;
  logic [BIT_W-1:0]     ffz_bit;
  logic [WORD_BITS-1:0] scan_bit;
  logic [WORD_BITS-1:0] num_bit;

  assign in_number = in_tdata[FIELD_W-1:0];
  assign in_cval   = in_tdata[2*FIELD_W-1:FIELD_W];
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_num_m1 = in_number - FIELD_W'(1);
  assign num_m1    = num_r - FIELD_W'(1);

  assign size      = (map_size_r > SIZE_MAX) ? SIZE_MAX : map_size_r;
  assign size_m1   = size - FIELD_W'(1);
  assign last_word = size_m1[BIT_W+ADDR_W-1:BIT_W];
  assign lim       = size - FIELD_W'({idx_r, {BIT_W{1'b0}}});
  assign mask      = (|lim[FIELD_W-1:BIT_W]) ? '1
                   : ((WORD_BITS'(1) << lim[BIT_W-1:0]) - WORD_BITS'(1));

  assign scan_bit  = WORD_BITS'(1) << ffz_bit;
  assign num_bit   = WORD_BITS'(1) << num_m1[BIT_W-1:0];

  assign rd_addr = (state_r == FSM_SCAN) ? idx_r + ADDR_W'(1)
                 : (in_cmd == CMD_ALLOC) ? '0
                 : in_num_m1[BIT_W+ADDR_W-1:BIT_W];

  bffa_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bffa_ffz u_ffz (
    .word_i  (rd_data | ~mask),
    .found   (ffz_found),
    .bit_idx (ffz_bit)
  );

  assign in_tready  = (state_r == FSM_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - 2*FIELD_W){1'b0}}, out_cnt_r, out_alloc_r};
  assign out_tuser  = out_stat_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    num_nxt       = num_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    res_alloc_nxt = res_alloc_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_alloc_nxt = out_alloc_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    wr            = '0;

    case (state_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = in_cmd;
          num_nxt       = in_number;
          idx_nxt       = '0;
          res_alloc_nxt = '0;
          res_stat_nxt  = STAT_OK;
          case (in_cmd)
            CMD_ALLOC: begin
              if (size == '0) begin
                res_stat_nxt = STAT_FULL;
                state_nxt    = FSM_DONE;
              end else begin
                state_nxt = FSM_SCAN;
              end
            end
            CMD_FREE, CMD_PRELOAD: begin
              if (in_number == '0 || in_number > size) begin
                res_stat_nxt = STAT_RANGE;
                state_nxt    = FSM_DONE;
              end else begin
                state_nxt = FSM_RMW;
              end
            end
            CMD_LOAD: begin
              cnt_nxt   = in_cval;
              state_nxt = FSM_DONE;
            end
            default: begin
              state_nxt = FSM_DONE;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        if (ffz_found) begin
          wr.en         = 1'b1;
          wr.addr       = idx_r;
          wr.data       = rd_data | scan_bit;
          res_alloc_nxt = FIELD_W'({idx_r, ffz_bit}) + FIELD_W'(1);
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - FIELD_W'(1);
          end
          state_nxt = FSM_DONE;
        end else if (idx_r == last_word) begin
          res_stat_nxt = STAT_FULL;
          state_nxt    = FSM_DONE;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      FSM_RMW: begin
        wr.en   = 1'b1;
        wr.addr = num_m1[BIT_W+ADDR_W-1:BIT_W];
        if (cmd_r == CMD_FREE) begin
          wr.data = rd_data & ~num_bit;
          if (cnt_r != COUNT_MAX) begin
            cnt_nxt = cnt_r + FIELD_W'(1);
          end
        end else begin
          wr.data = rd_data | num_bit;
        end
        state_nxt = FSM_DONE;
      end
      FSM_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_alloc_nxt = res_alloc_r;
          out_stat_nxt  = res_stat_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      map_size_r  <= SIZE_MAX;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (cfg_wr_en) begin
        map_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    num_r       <= num_nxt;
    res_alloc_r <= res_alloc_nxt;
    res_stat_r  <= res_stat_nxt;
    out_alloc_r <= out_alloc_nxt;
    out_stat_r  <= out_stat_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

endmodule

[rtl/bffa_ram.sv]
// bitmap word memory with per-word valid bits, one write and one registered read port
module bffa_ram
  import bffa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ram_wr_t              wr,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_r;
  logic [WORD_BITS-1:0] rd_q_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[rtl/bffa_ffz.sv]
// first-zero finder over one masked bitmap word
module bffa_ffz
  import bffa_pkg::*;
(
  input  logic [WORD_BITS-1:0] word_i,
  output logic                 found,
  output logic [BIT_W-1:0]     bit_idx
);

  always_comb begin
    found   = 1'b0;
    bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        found   = 1'b1;
        bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

[sim/bffa_checker.sv]
// checker for the bitmap first-fit allocator: predicts each result and compares it
`timescale 1ns / 100ps

module bffa_checker
  import bffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // number[13:0], count_value[27:14], zero pad
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // allocated[13:0], free_count[27:14], zero pad
  input  logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [FIELD_W-1:0] allocated;
    status_t            status;
    logic [FIELD_W-1:0] free_count;
  } alloc_result_t;

  bit [MAP_BITS-1:0]  used_map;
  logic [FIELD_W-1:0] free_cnt;
  logic [FIELD_W-1:0] map_size;
  alloc_result_t      expected_results[$];

  function automatic alloc_result_t apply_command(cmd_t cmd, logic [FIELD_W-1:0] number,
                                                  logic [FIELD_W-1:0] cval);
    alloc_result_t r;
    int unsigned   span;
    int            i;
    bit            found;
    span = (map_size > MAP_BITS) ? MAP_BITS : map_size;
    r.allocated = '0;
    r.status = STAT_OK;
    found = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        r.status = STAT_FULL;
        for (i = 0; i < span && !found; i++) begin
          if (!used_map[i]) begin
            used_map[i] = 1'b1;
            if (free_cnt != '0) free_cnt = free_cnt - 1'b1;
            r.allocated = FIELD_W'(i + 1);
            r.status = STAT_OK;
            found = 1'b1;
          end
        end
      end
      CMD_FREE, CMD_PRELOAD: begin
        if (number == '0 || number > span) begin
          r.status = STAT_RANGE;
        end else if (cmd == CMD_FREE) begin
          used_map[number - 1] = 1'b0;
          if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 1'b1;
        end else begin
          used_map[number - 1] = 1'b1;
        end
      end
      default: free_cnt = cval;
    endcase
    r.free_count = free_cnt;
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      used_map = '0;
      free_cnt = '0;
      map_size = SIZE_MAX;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) map_size = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat, actual allocated %0d status %0d free_count %0d",
                   $time, out_tdata[13:0], out_tuser, out_tdata[27:14]);
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("allocated", want.allocated, out_tdata[13:0]);
          compare_field("status", want.status, out_tuser);
          compare_field("free_count", want.free_count, out_tdata[27:14]);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_command(cmd_t'(in_tuser), in_tdata[13:0],
                                                 in_tdata[27:14]));
    end
    outstanding = expected_results.size();
  end

endmodule

[sim/tb_top.sv]
// testbench top for the bitmap first-fit allocator: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_top;
  import bffa_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 115;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // number[13:0], count_value[27:14], zero pad
  logic [1:0]  in_tuser;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // allocated[13:0], free_count[27:14], zero pad
  logic [1:0]  out_tuser;  // status[1:0]
  logic        cfg_wr_en;
  logic [13:0] cfg_wr_data;
  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_first_fit_allocator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  bffa_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (fail_count),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // random result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_beat(cmd_t cmd, logic [13:0] number, logic [13:0] cval);
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, cval, number};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_map_size(logic [13:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [13:0] pick_number(int unsigned span);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 14'(span + 1);
      2:       return 14'($urandom_range(0, 16383));
      3:       return 14'(span);
      default: return (span == 0) ? 14'd0 : 14'($urandom_range(1, span));
    endcase
  endfunction

  function automatic logic [13:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 14'h3fff;
      2:       return 14'd8192;
      3:       return 14'($urandom_range(0, 3));
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  task automatic random_beat(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send_beat(CMD_ALLOC, 14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
    else if (pick < 75)
      send_beat(CMD_FREE, pick_number(span), 14'($urandom_range(0, 16383)));
    else if (pick < 88)
      send_beat(CMD_PRELOAD, pick_number(span), 14'($urandom_range(0, 16383)));
    else
      send_beat(CMD_LOAD, 14'($urandom_range(0, 16383)), pick_count());
  endtask

  initial begin
    int          phase_size[PHASES];
    int unsigned span;
    int          p;
    int          k;
    phase_size = '{40, 8192, 1, 33, 100, 16383, 2, 0, 64, 31};
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full map after reset, counter at zero
    send_beat(CMD_ALLOC, 14'd0, 14'd0);
    send_beat(CMD_LOAD, 14'd0, 14'h3fff);
    send_beat(CMD_FREE, 14'd1, 14'd0);
    send_beat(CMD_FREE, 14'd1, 14'd0);
    send_beat(CMD_PRELOAD, 14'd8192, 14'd0);
    send_beat(CMD_PRELOAD, 14'd0, 14'd0);
    send_beat(CMD_FREE, 14'd8193, 14'd0);
    send_beat(CMD_FREE, 14'h3fff, 14'h3fff);
    send_beat(CMD_LOAD, 14'h3fff, 14'd0);
    send_beat(CMD_PRELOAD, 14'd2, 14'd0);
    send_beat(CMD_ALLOC, 14'h3fff, 14'h3fff);
    send_beat(CMD_ALLOC, 14'd0, 14'd0);
    send_beat(CMD_LOAD, 14'd0, 14'h2aaa);
    send_beat(CMD_LOAD, 14'd0, 14'h1555);
    send_beat(CMD_LOAD, 14'd0, 14'd8192);

    // empty map
    write_map_size(14'd0);
    send_beat(CMD_ALLOC, 14'd0, 14'd0);
    send_beat(CMD_FREE, 14'd1, 14'd0);
    send_beat(CMD_PRELOAD, 14'd1, 14'd0);

    // oversized map clamps to the full bitmap
    write_map_size(14'h3fff);
    send_beat(CMD_FREE, 14'd8192, 14'd0);
    send_beat(CMD_PRELOAD, 14'd8193, 14'd0);

    // single entry map
    write_map_size(14'd1);
    send_beat(CMD_ALLOC, 14'd0, 14'd0);
    send_beat(CMD_FREE, 14'd1, 14'd0);
    send_beat(CMD_ALLOC, 14'd0, 14'd0);
    send_beat(CMD_ALLOC, 14'd0, 14'd0);

    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) quiet = 1'b1;
      write_map_size(14'(phase_size[p]));
      span = (phase_size[p] > MAP_BITS) ? MAP_BITS : phase_size[p];
      for (k = 0; k < PHASE_BEATS; k++) begin
        if (p == 0 && k == 60) drain_results();
        sender_gap();
        random_beat(span);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
